// ===== rtl/bptc_pkg.sv =====
`default_nettype none

package bptc_pkg;

  // field widths
  localparam int RAW_W   = 24;
  localparam int COEFF_W = 16;
  localparam int TEMP_W  = 20;
  localparam int PRESS_W = 32;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEFF_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SENS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TCS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TCO      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TREF     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPSENS = 3'd5;

  // reference temperature, 20.00 degrees
  localparam logic signed [TEMP_W-1:0] TEMP_REF = 20'sd2000;

  typedef struct packed {
    logic [RAW_W-1:0] raw_temperature;
    logic [RAW_W-1:0] raw_pressure;
  } sample_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0]  temperature_centi;
    logic signed [PRESS_W-1:0] pressure_pa;
    logic                      low_temp_corrected;
  } result_t;

  typedef struct packed {
    logic [COEFF_W-1:0] sens;
    logic [COEFF_W-1:0] off;
    logic [COEFF_W-1:0] tcs;
    logic [COEFF_W-1:0] tco;
    logic [COEFF_W-1:0] tref;
    logic [COEFF_W-1:0] tempsens;
  } coeff_t;

endpackage

`default_nettype wire

// ===== rtl/bptc_coeff_regs.sv =====
`default_nettype none

module bptc_coeff_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [bptc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bptc_pkg::CFG_DATA_W-1:0] cfg_data,
  output bptc_pkg::coeff_t               coeff
);
  import bptc_pkg::*;

  // calibration word file, writes beyond the last index are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SENS:     coeff.sens     <= cfg_data;
        REG_OFF:      coeff.off      <= cfg_data;
        REG_TCS:      coeff.tcs      <= cfg_data;
        REG_TCO:      coeff.tco      <= cfg_data;
        REG_TREF:     coeff.tref     <= cfg_data;
        REG_TEMPSENS: coeff.tempsens <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/baro_pressure_temp_compensation.sv =====
`default_nettype none

// channel | dir | handshake                   | payload
// --------+-----+-----------------------------+-------------------------------------------------
// sample  | in  | sample_valid / sample_stall | raw_temperature, raw_pressure
// result  | out | result_valid / result_stall | temperature_centi, pressure_pa, low_temp_corrected
// cfg     | in  | cfg_write                   | cfg_index, cfg_data
//
// nine register stages; a beat enters every cycle unless sample_stall is high
// throughput of one beat per cycle, while result_stall is low, is set by the stage chain, each stage
// holding at most one level of parallel multiplies or a short chain of adds
// each stage advances when it is empty or the stage after it advances, so bubbles
// close up while the result register waits
// rst is synchronous and clears the valid bits and the calibration words

module baro_pressure_temp_compensation (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  bptc_pkg::sample_t               sample,
  output logic                            result_valid,
  input  logic                            result_stall,
  output bptc_pkg::result_t               result,
  input  logic                            cfg_write,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bptc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bptc_pkg::*;

  localparam int STAGES = 9;
  localparam int DT_W   = RAW_W + 1;
  localparam int MC_W   = DT_W + COEFF_W + 1;
  localparam int DD_W   = 2 * DT_W;
  localparam int DIFF_W = 18;
  localparam int SQ_W   = 35;
  localparam int OFF1_W = 35;
  localparam int SNS1_W = 34;
  localparam int OFF_W  = 38;
  localparam int SNS_W  = 37;
  localparam int T2_W   = 17;
  localparam int SPLIT  = 19;
  localparam int PP_W   = RAW_W + SPLIT;
  localparam int PROD_W = 62;
  localparam int X_W    = 41;

  coeff_t coeff;

  bptc_coeff_regs u_coeff (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coeff     (coeff)
  );

  // stage valid bits and advance chain
  logic [STAGES:1] vld;
  logic [STAGES:1] ready;

  always_comb begin
    ready[STAGES] = !vld[STAGES] || !result_stall;
    for (int k = STAGES - 1; k >= 1; k--) begin
      ready[k] = !vld[k] || ready[k+1];
    end
  end

  assign sample_stall = !ready[1];
  assign result_valid = vld[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ready[1]) begin
        vld[1] <= sample_valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (ready[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: dT = D2 - C5 * 256
  logic signed [DT_W-1:0] s1_dt;
  logic [RAW_W-1:0]       s1_d1;

  always_ff @(posedge clk) begin
    if (ready[1]) begin
      s1_dt <= $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, coeff.tref, 8'h00});
      s1_d1 <= sample.raw_pressure;
    end
  end

  // stage 2: products of dT with C6, C4, C3 and itself
  logic signed [MC_W-1:0] mul_c6, mul_c4, mul_c3;
  logic signed [DD_W-1:0] mul_dd;

  assign mul_c6 = s1_dt * $signed({1'b0, coeff.tempsens});
  assign mul_c4 = s1_dt * $signed({1'b0, coeff.tco});
  assign mul_c3 = s1_dt * $signed({1'b0, coeff.tcs});
  assign mul_dd = s1_dt * s1_dt;

  logic signed [MC_W-1:0] s2_p6, s2_p4, s2_p3;
  logic signed [DD_W-1:0] s2_pdd;
  logic [RAW_W-1:0]       s2_d1;

  always_ff @(posedge clk) begin
    if (ready[2]) begin
      s2_p6  <= mul_c6;
      s2_p4  <= mul_c4;
      s2_p3  <= mul_c3;
      s2_pdd <= mul_dd;
      s2_d1  <= s1_d1;
    end
  end

  // stage 3: first-order temperature offset, OFF, SENS and T2
  logic signed [MC_W-1:0]   c6_adj;
  logic signed [DIFF_W-1:0] diff_next;
  logic signed [OFF1_W-1:0] off1_next;
  logic signed [SNS1_W-1:0] sens1_next;

  // divide by 2^23 toward zero: bias negative values before the shift
  assign c6_adj     = s2_p6 + (s2_p6[MC_W-1] ? MC_W'(8388607) : MC_W'(0));
  assign diff_next  = c6_adj[DIFF_W+22:23];
  assign off1_next  = $signed({3'b000, coeff.off, 16'h0000}) + $signed(s2_p4[MC_W-1:7]);
  assign sens1_next = $signed({3'b000, coeff.sens, 15'h0000}) + $signed(s2_p3[MC_W-1:8]);

  logic signed [DIFF_W-1:0] s3_diff;
  logic signed [OFF1_W-1:0] s3_off1;
  logic signed [SNS1_W-1:0] s3_sens1;
  logic [T2_W-1:0]          s3_t2;
  logic [RAW_W-1:0]         s3_d1;

  always_ff @(posedge clk) begin
    if (ready[3]) begin
      s3_diff  <= diff_next;
      s3_off1  <= off1_next;
      s3_sens1 <= sens1_next;
      s3_t2    <= s2_pdd[T2_W+30:31];
      s3_d1    <= s2_d1;
    end
  end

  // stage 4: (TEMP - 2000)^2
  logic signed [2*DIFF_W-1:0] sq_full;

  assign sq_full = s3_diff * s3_diff;

  logic [SQ_W-1:0]          s4_sq;
  logic signed [DIFF_W-1:0] s4_diff;
  logic signed [OFF1_W-1:0] s4_off1;
  logic signed [SNS1_W-1:0] s4_sens1;
  logic [T2_W-1:0]          s4_t2;
  logic [RAW_W-1:0]         s4_d1;

  always_ff @(posedge clk) begin
    if (ready[4]) begin
      s4_sq    <= sq_full[SQ_W-1:0];
      s4_diff  <= s3_diff;
      s4_off1  <= s3_off1;
      s4_sens1 <= s3_sens1;
      s4_t2    <= s3_t2;
      s4_d1    <= s3_d1;
    end
  end

  // stage 5: second-order correction below 20.00 degrees
  logic [SQ_W+2:0]          sq5;
  logic                     low;
  logic signed [OFF_W-1:0]  off_next;
  logic signed [SNS_W-1:0]  sens_next;
  logic signed [TEMP_W-1:0] temp_next;

  assign sq5  = {1'b0, s4_sq, 2'b00} + {3'b000, s4_sq};
  assign low  = s4_diff[DIFF_W-1];
  assign off_next = {{(OFF_W-OFF1_W){s4_off1[OFF1_W-1]}}, s4_off1}
                  - (low ? {1'b0, sq5[SQ_W+2:1]} : OFF_W'(0));
  assign sens_next = {{(SNS_W-SNS1_W){s4_sens1[SNS1_W-1]}}, s4_sens1}
                   - (low ? {1'b0, sq5[SQ_W+2:2]} : SNS_W'(0));
  assign temp_next = TEMP_REF + {{(TEMP_W-DIFF_W){s4_diff[DIFF_W-1]}}, s4_diff}
                   - (low ? {{(TEMP_W-T2_W){1'b0}}, s4_t2} : TEMP_W'(0));

  logic signed [OFF_W-1:0]  s5_off;
  logic signed [SNS_W-1:0]  s5_sens;
  logic signed [TEMP_W-1:0] s5_temp;
  logic                     s5_low;
  logic [RAW_W-1:0]         s5_d1;

  always_ff @(posedge clk) begin
    if (ready[5]) begin
      s5_off  <= off_next;
      s5_sens <= sens_next;
      s5_temp <= temp_next;
      s5_low  <= low;
      s5_d1   <= s4_d1;
    end
  end

  // stage 6: D1 * SENS as two partial products
  logic [PP_W-1:0]        pp_lo;
  logic signed [PP_W-1:0] pp_hi;

  assign pp_lo = s5_d1 * s5_sens[SPLIT-1:0];
  assign pp_hi = $signed({1'b0, s5_d1}) * $signed(s5_sens[SNS_W-1:SPLIT]);

  logic [PP_W-1:0]          s6_lo;
  logic signed [PP_W-1:0]   s6_hi;
  logic signed [OFF_W-1:0]  s6_off;
  logic signed [TEMP_W-1:0] s6_temp;
  logic                     s6_low;

  always_ff @(posedge clk) begin
    if (ready[6]) begin
      s6_lo   <= pp_lo;
      s6_hi   <= pp_hi;
      s6_off  <= s5_off;
      s6_temp <= s5_temp;
      s6_low  <= s5_low;
    end
  end

  // stage 7: combine partial products
  logic signed [PROD_W-1:0] s7_prod;
  logic signed [OFF_W-1:0]  s7_off;
  logic signed [TEMP_W-1:0] s7_temp;
  logic                     s7_low;

  always_ff @(posedge clk) begin
    if (ready[7]) begin
      s7_prod <= {s6_hi, {SPLIT{1'b0}}} + {{SPLIT{1'b0}}, s6_lo};
      s7_off  <= s6_off;
      s7_temp <= s6_temp;
      s7_low  <= s6_low;
    end
  end

  // stage 8: (D1 * SENS) >> 21 - OFF
  logic signed [X_W-1:0]    s8_x;
  logic signed [TEMP_W-1:0] s8_temp;
  logic                     s8_low;

  always_ff @(posedge clk) begin
    if (ready[8]) begin
      s8_x    <= s7_prod[PROD_W-1:21] - {{(X_W-OFF_W){s7_off[OFF_W-1]}}, s7_off};
      s8_temp <= s7_temp;
      s8_low  <= s7_low;
    end
  end

  // stage 9: divide by 32768 toward zero into the result register
  logic signed [X_W-1:0] x_adj;

  assign x_adj = s8_x + (s8_x[X_W-1] ? X_W'(32767) : X_W'(0));

  // quotient stays below 2^25 in magnitude, inside the 32-bit clamp range
  always_ff @(posedge clk) begin
    if (ready[9]) begin
      result.temperature_centi  <= s8_temp;
      result.pressure_pa        <= {{(PRESS_W-(X_W-15)){x_adj[X_W-1]}}, x_adj[X_W-1:15]};
      result.low_temp_corrected <= s8_low;
    end
  end

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (&vld))
    else $error("input stalled while a stage is empty");

  a_low_flag_matches_temp: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.low_temp_corrected == (result.temperature_centi < TEMP_REF)))
    else $error("low temperature flag disagrees with temperature");

  a_last_stage_delivers: assert property (@(posedge clk) disable iff (rst)
    (vld[STAGES-1] && ready[STAGES]) |=> result_valid)
    else $error("beat lost between last stage and result register");

endmodule

`default_nettype wire

// ===== sim/baro_pressure_temp_compensation_tb.sv =====
module baro_pressure_temp_compensation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bptc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_BEATS  = 200;

  // indexes past the last register, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [RAW_W-1:0]   RAW_MAX   = '1;
  localparam logic [COEFF_W-1:0] COEFF_MAX = '1;
  localparam longint PRESS_MAX = (longint'(1) << (PRESS_W - 1)) - 1;
  localparam longint PRESS_MIN = -(longint'(1) << (PRESS_W - 1));

  logic                  clk;
  logic                  rst;
  logic                  sample_valid;
  logic                  sample_stall;
  sample_t               sample;
  logic                  result_valid;
  logic                  result_stall;
  result_t               result;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  coeff_t  calib;
  result_t pending_results[$];
  result_t want;
  int      failures = 0;
  int      cycle_count = 0;
  int      hold_left = 0;
  bit      jitter_on = 1'b1;

  baro_pressure_temp_compensation u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // compensated temperature and pressure for one sample pair
  function automatic result_t compensate(input sample_t s, input coeff_t c);
    longint  d1, d2, c1, c2, c3, c4, c5, c6;
    longint  dt, tc, offset, sensitivity, sq, p;
    result_t r;
    d2 = s.raw_temperature;
    d1 = s.raw_pressure;
    c1 = c.sens;
    c2 = c.off;
    c3 = c.tcs;
    c4 = c.tco;
    c5 = c.tref;
    c6 = c.tempsens;
    dt          = d2 - c5 * 256;
    tc          = 2000 + (dt * c6) / 8388608;
    offset      = c2 * 65536 + ((c4 * dt) >>> 7);
    sensitivity = c1 * 32768 + ((c3 * dt) >>> 8);
    r.low_temp_corrected = 1'b0;
    // second-order term below 20.00 degrees
    if (tc < 2000) begin
      sq          = (tc - 2000) * (tc - 2000);
      tc          = tc - ((dt * dt) >>> 31);
      offset      = offset - ((5 * sq) >>> 1);
      sensitivity = sensitivity - ((5 * sq) >>> 2);
      r.low_temp_corrected = 1'b1;
    end
    p = (((d1 * sensitivity) >>> 21) - offset) / 32768;
    if (p > PRESS_MAX) p = PRESS_MAX;
    if (p < PRESS_MIN) p = PRESS_MIN;
    r.temperature_centi = tc[TEMP_W-1:0];
    r.pressure_pa       = p[PRESS_W-1:0];
    return r;
  endfunction

  // local copy of the calibration words
  function automatic void store_coeff(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SENS:     calib.sens     = data;
      REG_OFF:      calib.off      = data;
      REG_TCS:      calib.tcs      = data;
      REG_TCO:      calib.tco      = data;
      REG_TREF:     calib.tref     = data;
      REG_TEMPSENS: calib.tempsens = data;
      default: ;
    endcase
  endfunction

  // receiver: random stall, or a counted hold-off when asked
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= jitter_on && ($urandom_range(99) < 15);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no prediction pending");
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (result.temperature_centi !== want.temperature_centi) begin
          $error("temperature_centi: expected %0d, got %0d",
                 want.temperature_centi, result.temperature_centi);
          failures++;
        end
        if (result.pressure_pa !== want.pressure_pa) begin
          $error("pressure_pa: expected %0d, got %0d",
                 want.pressure_pa, result.pressure_pa);
          failures++;
        end
        if (result.low_temp_corrected !== want.low_temp_corrected) begin
          $error("low_temp_corrected: expected %0b, got %0b",
                 want.low_temp_corrected, result.low_temp_corrected);
          failures++;
        end
      end
    end
  end

  // one sample beat, with an optional idle gap ahead of it
  task automatic send_sample(input logic [RAW_W-1:0] temp_raw,
                             input logic [RAW_W-1:0] press_raw);
    sample_t s;
    s.raw_temperature = temp_raw;
    s.raw_pressure    = press_raw;
    if (jitter_on && $urandom_range(99) < 15) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    pending_results.push_back(compensate(s, calib));
  endtask

  // drop valid and let the pipeline empty
  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    store_coeff(idx, data);
  endtask

  // full calibration load, spare indexes hit first
  task automatic load_calibration(input coeff_t c);
    wait_idle();
    write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
    write_reg(REG_SENS, c.sens);
    write_reg(REG_OFF, c.off);
    write_reg(REG_TCS, c.tcs);
    write_reg(REG_TCO, c.tco);
    write_reg(REG_TREF, c.tref);
    write_reg(REG_TEMPSENS, c.tempsens);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic coeff_t typical_calibration();
    coeff_t c;
    c.sens     = 16'd41000;
    c.off      = 16'd37500;
    c.tcs      = 16'd24000;
    c.tco      = 16'd23500;
    c.tref     = 16'd33000;
    c.tempsens = 16'd28500;
    return c;
  endfunction

  function automatic logic [COEFF_W-1:0] pick_word(input int kind,
                                                   input logic [COEFF_W-1:0] base);
    case (kind)
      0: return COEFF_W'($urandom_range(0, 65535));
      1: return base + COEFF_W'($urandom_range(0, 8191)) - COEFF_W'(4096);
      default: begin
        case ($urandom_range(2))
          0: return '0;
          1: return COEFF_MAX;
          default: return COEFF_W'($urandom_range(0, 65535));
        endcase
      end
    endcase
  endfunction

  function automatic coeff_t random_calibration(input int kind);
    coeff_t t;
    coeff_t c;
    t = typical_calibration();
    c.sens     = pick_word(kind, t.sens);
    c.off      = pick_word(kind, t.off);
    c.tcs      = pick_word(kind, t.tcs);
    c.tco      = pick_word(kind, t.tco);
    c.tref     = pick_word(kind, t.tref);
    c.tempsens = pick_word(kind, t.tempsens);
    return c;
  endfunction

  // raw temperature around the reference point, clamped to 24 bits
  function automatic logic [RAW_W-1:0] temp_near_ref(input int spread);
    longint v;
    longint jitter;
    jitter = $urandom_range(0, 2 * spread);
    v = longint'(calib.tref) * 256 + jitter - spread;
    if (v < 0) v = 0;
    if (v > longint'(RAW_MAX)) v = RAW_MAX;
    return v[RAW_W-1:0];
  endfunction

  function automatic logic [RAW_W-1:0] random_temp_raw();
    case ($urandom_range(9))
      0, 1, 2: return RAW_W'($urandom);
      3:       return $urandom_range(1) ? RAW_MAX : '0;
      4, 5:    return temp_near_ref(4000);
      default: return temp_near_ref(1 << 18);
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] random_press_raw();
    case ($urandom_range(9))
      0:       return '0;
      1:       return RAW_MAX;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  // calibration words at reset are all zero
  task automatic test_reset_calibration();
    send_sample('0, '0);
    send_sample(RAW_MAX, RAW_MAX);
    send_sample(24'hAAAAAA, 24'h555555);
    send_sample(24'h555555, 24'hAAAAAA);
  endtask

  // typical part, reference point and the truncation edge at 20.00 degrees
  task automatic test_typical_calibration();
    logic [RAW_W-1:0] ref_raw;
    load_calibration(typical_calibration());
    ref_raw = {calib.tref, 8'h00};
    send_sample(ref_raw, 24'd8000000);
    send_sample(ref_raw - 24'd294, 24'd8000000);
    send_sample(ref_raw - 24'd295, 24'd8000000);
    send_sample(ref_raw + 24'd295, 24'd8000000);
    send_sample('0, RAW_MAX);
    send_sample(RAW_MAX, '0);
    send_sample(RAW_MAX, RAW_MAX);
    send_sample('0, '0);
    send_sample(ref_raw - 24'h100000, 24'hAAAAAA);
    send_sample(ref_raw + 24'h100000, 24'h555555);
    send_sample(ref_raw - 24'd3000000, 24'd9000000);
    send_sample(ref_raw + 24'd3000000, 24'd9000000);
  endtask

  // register extremes, deepest cold, negative sensitivity, hottest reading
  task automatic test_extreme_calibration();
    coeff_t c;
    c = '{default: COEFF_MAX};
    load_calibration(c);
    send_sample('0, RAW_MAX);
    send_sample(RAW_MAX, RAW_MAX);
    send_sample('0, '0);
    c.sens = '0;
    c.off  = '0;
    load_calibration(c);
    send_sample('0, RAW_MAX);
    send_sample(24'h800000, 24'h7FFFFF);
    c = '{default: COEFF_MAX};
    c.tref = '0;
    load_calibration(c);
    send_sample(RAW_MAX, RAW_MAX);
    send_sample(RAW_MAX, '0);
  endtask

  // random calibration phases, one of them with no idling at all
  task automatic test_random_phases();
    for (int phase = 0; phase < 6; phase++) begin
      load_calibration(random_calibration(phase % 3));
      jitter_on = (phase != 1);
      for (int n = 0; n < PHASE_BEATS; n++)
        send_sample(random_temp_raw(), random_press_raw());
    end
    jitter_on = 1'b1;
  endtask

  // long receiver hold-off while samples keep coming, pipeline fills up
  task automatic test_backpressure();
    load_calibration(random_calibration(1));
    hold_left = 120;
    for (int n = 0; n < 60; n++)
      send_sample(random_temp_raw(), random_press_raw());
  endtask

  initial begin
    calib        = '0;
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample       <= '0;
    cfg_write    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_calibration();
    test_typical_calibration();
    test_extreme_calibration();
    test_random_phases();
    test_backpressure();
    wait_idle();

    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
